// ===== rtl/smt_pkg.sv =====
// smt_pkg: shared constants, types and helpers for the sorted multiset table
// no dependencies; imported by smt_ctrl, smt_datapath and sorted_multiset_table_core
package smt_pkg;

	localparam int MAX_DISTINCT = 64;
	localparam int COUNT_BITS   = 16;
	localparam int VALUE_BITS   = 32;

	localparam int USED_BITS  = $clog2(MAX_DISTINCT + 1);
	localparam int TOTAL_BITS = 22;
	localparam int OCC_BITS   = 16;
	localparam int DIST_BITS  = 7;
	localparam int ITEM_BITS  = 32;
	localparam int REQ_BITS   = 2;
	localparam int STAT_BITS  = 2;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};
	localparam logic [USED_BITS-1:0]  USED_FULL = USED_BITS'(MAX_DISTINCT);

	localparam logic [REQ_BITS-1:0] REQ_ADD    = 2'd0;
	localparam logic [REQ_BITS-1:0] REQ_REMOVE = 2'd1;

	localparam logic [STAT_BITS-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_BITS-1:0] ST_ABSENT = 2'd1;
	localparam logic [STAT_BITS-1:0] ST_FULL   = 2'd2;
	localparam logic [STAT_BITS-1:0] ST_SAT    = 2'd3;

	typedef struct packed {
		logic load;
		logic cmp;
		logic look;
		logic exec;
	} smt_cmd_t;

	function automatic logic [VALUE_BITS-1:0] fit_value(input logic [ITEM_BITS-1:0] v);
		logic [VALUE_BITS+ITEM_BITS-1:0] tmp;
		tmp = {{VALUE_BITS{v[ITEM_BITS-1]}}, v};
		return tmp[VALUE_BITS-1:0];
	endfunction

	function automatic logic [OCC_BITS-1:0] fit_occ(input logic [COUNT_BITS-1:0] c);
		logic [OCC_BITS+COUNT_BITS-1:0] tmp;
		tmp = {{OCC_BITS{1'b0}}, c};
		return tmp[OCC_BITS-1:0];
	endfunction

	function automatic logic [DIST_BITS-1:0] fit_dist(input logic [USED_BITS-1:0] u);
		logic [DIST_BITS+USED_BITS-1:0] tmp;
		tmp = {{DIST_BITS{1'b0}}, u};
		return tmp[DIST_BITS-1:0];
	endfunction

endpackage

// ===== rtl/smt_ctrl.sv =====
// smt_ctrl: sequencer for load, compare, lookup and execute steps plus output valid
// depends on smt_pkg
module smt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output smt_pkg::smt_cmd_t cmd
);
	import smt_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_CMP, S_LOOK, S_EXEC} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	assign cmd.load = in_valid && (state_q == S_IDLE);
	assign cmd.cmp  = (state_q == S_CMP);
	assign cmd.look = (state_q == S_LOOK);
	assign cmd.exec = (state_q == S_EXEC) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_EXEC) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_CMP;
				end
				S_CMP: begin
					state_q <= S_LOOK;
				end
				S_LOOK: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/smt_datapath.sv =====
// smt_datapath: row of compare-and-shift cells, totals and result register
// depends on smt_pkg; sequenced by smt_ctrl through smt_cmd_t
module smt_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  smt_pkg::smt_cmd_t               cmd,
	input  logic                            cfg_we,
	input  logic                            cfg_desc,
	input  logic [smt_pkg::REQ_BITS-1:0]    in_req,
	input  logic [smt_pkg::ITEM_BITS-1:0]   in_item,
	output logic [smt_pkg::STAT_BITS-1:0]   res_status,
	output logic                            res_present,
	output logic [smt_pkg::OCC_BITS-1:0]    res_occ,
	output logic [smt_pkg::TOTAL_BITS-1:0]  res_total,
	output logic [smt_pkg::DIST_BITS-1:0]   res_distinct
);
	import smt_pkg::*;

	logic                         desc_q;
	logic [REQ_BITS-1:0]          req_q;
	logic signed [VALUE_BITS-1:0] key_q;
	logic [USED_BITS-1:0]         used_q;
	logic [TOTAL_BITS-1:0]        total_q;

	logic signed [VALUE_BITS-1:0] val_q [MAX_DISTINCT];
	logic [COUNT_BITS-1:0]        cnt_q [MAX_DISTINCT];

	logic [MAX_DISTINCT-1:0] le_s1, eq_s1, at_used_s1;
	logic [MAX_DISTINCT-1:0] hit, ins, from_pos;
	logic [MAX_DISTINCT-1:0] hit_s2, ins_s2, from_pos_s2;
	logic                    seen;
	logic                    found_s2;
	logic [COUNT_BITS-1:0]   cnt_s2;
	logic [COUNT_BITS-1:0]   sel_cnt;

	logic                    is_add, is_rem, sat, full;
	logic                    do_inc, do_ins, do_dec, do_del;
	logic [COUNT_BITS-1:0]   cnt_dec;
	logic [USED_BITS-1:0]    used_nx;
	logic [TOTAL_BITS-1:0]   total_nx;
	logic [STAT_BITS-1:0]    status_nx;
	logic                    present_nx;
	logic [COUNT_BITS-1:0]   occ_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q <= 1'b0;
		end else if (cfg_we) begin
			desc_q <= cfg_desc;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_req;
			key_q <= fit_value(in_item);
		end
	end

	// lookup: first cell where the key orders before or equal, and every cell from there on
	always_comb begin
		seen    = 1'b0;
		sel_cnt = '0;
		for (int i = 0; i < MAX_DISTINCT; i++) begin
			hit[i]      = le_s1[i] && !seen;
			seen        = seen || le_s1[i];
			from_pos[i] = seen;
			ins[i]      = hit[i] || (!(|le_s1) && at_used_s1[i]);
			sel_cnt     = sel_cnt | (hit[i] ? cnt_q[i] : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			hit_s2      <= hit;
			ins_s2      <= ins;
			from_pos_s2 <= from_pos;
			found_s2    <= |(hit & eq_s1);
			cnt_s2      <= sel_cnt;
		end
	end

	always_comb begin
		is_add  = (req_q == REQ_ADD);
		is_rem  = (req_q == REQ_REMOVE);
		sat     = (cnt_s2 == COUNT_MAX);
		full    = (used_q >= USED_FULL);
		cnt_dec = cnt_s2 - COUNT_BITS'(cnt_s2 != '0);
		do_inc  = is_add && found_s2 && !sat;
		do_ins  = is_add && !found_s2 && !full;
		do_dec  = is_rem && found_s2;
		do_del  = do_dec && (cnt_dec == '0);

		used_nx = used_q;
		if (do_ins) used_nx = used_q + USED_BITS'(1);
		else if (do_del) used_nx = used_q - USED_BITS'(1);

		total_nx = total_q;
		if ((do_inc || do_ins) && (total_q != TOTAL_MAX)) total_nx = total_q + TOTAL_BITS'(1);
		else if (do_dec && (total_q != '0)) total_nx = total_q - TOTAL_BITS'(1);

		status_nx  = ST_OK;
		present_nx = 1'b0;
		occ_nx     = '0;
		if (is_add) begin
			if (found_s2) begin
				present_nx = 1'b1;
				if (sat) begin
					status_nx = ST_SAT;
					occ_nx    = cnt_s2;
				end else begin
					occ_nx = cnt_s2 + COUNT_BITS'(1);
				end
			end else if (full) begin
				status_nx = ST_FULL;
			end else begin
				present_nx = 1'b1;
				occ_nx     = COUNT_BITS'(1);
			end
		end else if (found_s2) begin
			if (is_rem) begin
				present_nx = !do_del;
				occ_nx     = cnt_dec;
			end else begin
				present_nx = 1'b1;
				occ_nx     = cnt_s2;
			end
		end else begin
			status_nx = ST_ABSENT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			total_q <= '0;
		end else if (cmd.exec) begin
			used_q  <= used_nx;
			total_q <= total_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_status   <= status_nx;
			res_present  <= present_nx;
			res_occ      <= fit_occ(occ_nx);
			res_total    <= total_nx;
			res_distinct <= fit_dist(used_nx);
		end
	end

	genvar g;
	generate
		for (g = 0; g < MAX_DISTINCT; g++) begin : g_cell
			logic                         up_ok, dn_ok;
			logic signed [VALUE_BITS-1:0] up_val, dn_val;
			logic [COUNT_BITS-1:0]        up_cnt, dn_cnt;
			logic                         vld;

			if (g == 0) begin : g_first
				assign up_ok  = 1'b0;
				assign up_val = val_q[g];
				assign up_cnt = cnt_q[g];
			end else begin : g_mid_up
				assign up_ok  = from_pos_s2[g-1];
				assign up_val = val_q[g-1];
				assign up_cnt = cnt_q[g-1];
			end

			if (g == MAX_DISTINCT - 1) begin : g_last
				assign dn_ok  = 1'b0;
				assign dn_val = val_q[g];
				assign dn_cnt = cnt_q[g];
			end else begin : g_mid_dn
				assign dn_ok  = from_pos_s2[g];
				assign dn_val = val_q[g+1];
				assign dn_cnt = cnt_q[g+1];
			end

			assign vld = (USED_BITS'(g) < used_q);

			always_ff @(posedge clk) begin
				if (cmd.cmp) begin
					le_s1[g]      <= vld && (desc_q ? (key_q >= val_q[g]) : (key_q <= val_q[g]));
					eq_s1[g]      <= vld && (key_q == val_q[g]);
					at_used_s1[g] <= (USED_BITS'(g) == used_q);
				end
			end

			always_ff @(posedge clk) begin
				if (cmd.exec) begin
					if (do_ins) begin
						if (ins_s2[g]) begin
							val_q[g] <= key_q;
							cnt_q[g] <= COUNT_BITS'(1);
						end else if (up_ok) begin
							val_q[g] <= up_val;
							cnt_q[g] <= up_cnt;
						end
					end else if (do_del) begin
						if (dn_ok) begin
							val_q[g] <= dn_val;
							cnt_q[g] <= dn_cnt;
						end
					end else if (hit_s2[g]) begin
						if (do_inc) cnt_q[g] <= cnt_s2 + COUNT_BITS'(1);
						else if (do_dec) cnt_q[g] <= cnt_dec;
					end
				end
			end
		end
	endgenerate

endmodule

// ===== rtl/sorted_multiset_table_core.sv =====
// Sorted multiset table core: up to 64 distinct signed values kept in sorted order
// (ascending, or descending when sort_descending is written 1), each with a 16-bit
// saturating count. Requests on the slave stream are add, remove and query; every
// request gives one result beat with status, presence, count, running total and
// distinct count. A request is taken only when the core is idle; its result beat is
// offered at the end of its steps (parallel compare in every cell, lookup of the first
// matching cell, update with shift), and the next request can be taken once the update
// is done. The steps are set by the single compare-and-shift cell row. A new request
// is taken while the previous result still waits on the master stream, and then holds
// in its update step until that beat leaves. The configuration register must be
// written only while no request is in flight.
// depends on smt_pkg, smt_ctrl, smt_datapath
module sorted_multiset_table_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,       // sort_descending
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // item_value[31:0]
	input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // present[0], occurrences[16:1], total_count[38:17],
	                                    // distinct_count[45:39], zero[47:46]
	output logic [1:0]  m_axis_tuser    // status[1:0]
);
	import smt_pkg::*;

	smt_cmd_t              cmd;
	logic [STAT_BITS-1:0]  res_status;
	logic                  res_present;
	logic [OCC_BITS-1:0]   res_occ;
	logic [TOTAL_BITS-1:0] res_total;
	logic [DIST_BITS-1:0]  res_distinct;

	assign cfg_ready = 1'b1;

	smt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	smt_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_we       (cfg_valid),
		.cfg_desc     (cfg_data),
		.in_req       (s_axis_tuser),
		.in_item      (s_axis_tdata),
		.res_status   (res_status),
		.res_present  (res_present),
		.res_occ      (res_occ),
		.res_total    (res_total),
		.res_distinct (res_distinct)
	);

	assign m_axis_tdata = {2'b00, res_distinct, res_total, res_occ, res_present};
	assign m_axis_tuser = res_status;

`ifndef SYNTH
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while another is in flight");

	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata[16:1] == '0))
		else $error("absent value reports nonzero count");

	a_full_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_FULL) |->
		(m_axis_tdata[45:39] == fit_dist(USED_FULL)))
		else $error("table full reported below capacity");

	a_present_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ((m_axis_tuser == ST_ABSENT) || (m_axis_tuser == ST_FULL)) |->
		!m_axis_tdata[0])
		else $error("present flag set with failing status");
`endif

endmodule

// ===== tb/sorted_multiset_table_core_test.sv =====
`timescale 1ns / 100ps
// sorted_multiset_table_core_test: self-checking bench for the sorted multiset table core
// keeps a shadow table of values and counts, predicts every result beat and compares fields
// depends on smt_pkg and sorted_multiset_table_core
module sorted_multiset_table_core_test;
	import smt_pkg::*;

	localparam logic [REQ_BITS-1:0] REQ_QUERY = 2'd2;
	localparam logic [REQ_BITS-1:0] REQ_SPARE = 2'd3;

	localparam int POOL_SIZE     = 48;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 10;
	localparam int QUIET_LIMIT   = 3000;
	localparam int MAX_REPORTS   = 40;
	localparam int PROBE_ROWS    = 22;

	typedef struct packed {
		logic [STAT_BITS-1:0]  status;
		logic                  present;
		logic [OCC_BITS-1:0]   occurrences;
		logic [TOTAL_BITS-1:0] total_count;
		logic [DIST_BITS-1:0]  distinct_count;
	} tally_t;

	typedef struct {
		logic [REQ_BITS-1:0]  req;
		logic [ITEM_BITS-1:0] value;
		bit                   literal;
		tally_t               want;
	} probe_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // item_value[31:0]
	logic [1:0]  s_axis_tuser;   // req_type[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;   // present[0], occurrences[16:1], total_count[38:17],
	                             // distinct_count[45:39], zero[47:46]
	logic [1:0]  m_axis_tuser;   // status[1:0]

	// shadow of the table
	logic signed [VALUE_BITS-1:0] shadow_vals [MAX_DISTINCT];
	logic [COUNT_BITS-1:0]        shadow_cnts [MAX_DISTINCT];
	int                           shadow_used;
	logic [TOTAL_BITS-1:0]        shadow_total;
	bit                           order_desc;

	tally_t     pending_tallies[$];
	probe_row_t probe_rows [PROBE_ROWS];
	logic [ITEM_BITS-1:0] value_pool [POOL_SIZE];

	bit     beat_literal;
	tally_t beat_want;
	int     send_idle_pct;
	int     recv_idle_pct;
	bit     hold_request;
	int     mismatch_count;
	int     quiet_cycles;

	sorted_multiset_table_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input longint want, input longint got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t mismatch %s: expected %0d got %0d", $time, what, want, got);
	endtask

	// first slot where the key orders before or equal to the stored value
	function automatic int locate(input logic signed [VALUE_BITS-1:0] key, output bit hit);
		int pos;
		pos = 0;
		while (pos < shadow_used &&
		       !(order_desc ? (key >= shadow_vals[pos]) : (key <= shadow_vals[pos])))
			pos++;
		hit = 1'b0;
		if (pos < shadow_used)
			hit = (shadow_vals[pos] == key);
		return pos;
	endfunction

	function automatic tally_t apply_request(input logic [REQ_BITS-1:0] req,
	                                         input logic [ITEM_BITS-1:0] raw);
		tally_t                       t;
		logic signed [VALUE_BITS-1:0] key;
		int                           pos;
		int                           i;
		bit                           hit;
		key = raw;
		pos = locate(key, hit);
		t = '0;
		t.status = ST_OK;
		case (req)
			REQ_ADD: begin
				if (hit) begin
					t.present = 1'b1;
					if (shadow_cnts[pos] == COUNT_MAX)
						t.status = ST_SAT;
					else begin
						shadow_cnts[pos]++;
						if (shadow_total != TOTAL_MAX)
							shadow_total++;
					end
					t.occurrences = shadow_cnts[pos];
				end else if (shadow_used >= MAX_DISTINCT) begin
					t.status = ST_FULL;
				end else begin
					for (i = shadow_used; i > pos; i--) begin
						shadow_vals[i] = shadow_vals[i-1];
						shadow_cnts[i] = shadow_cnts[i-1];
					end
					shadow_vals[pos] = key;
					shadow_cnts[pos] = COUNT_BITS'(1);
					shadow_used++;
					if (shadow_total != TOTAL_MAX)
						shadow_total++;
					t.present = 1'b1;
					t.occurrences = OCC_BITS'(1);
				end
			end
			REQ_REMOVE: begin
				if (!hit)
					t.status = ST_ABSENT;
				else begin
					if (shadow_cnts[pos] != 0)
						shadow_cnts[pos]--;
					if (shadow_total != 0)
						shadow_total--;
					t.occurrences = shadow_cnts[pos];
					if (shadow_cnts[pos] == 0) begin
						for (i = pos; i + 1 < shadow_used; i++) begin
							shadow_vals[i] = shadow_vals[i+1];
							shadow_cnts[i] = shadow_cnts[i+1];
						end
						shadow_used--;
					end else
						t.present = 1'b1;
				end
			end
			default: begin
				if (hit) begin
					t.present = 1'b1;
					t.occurrences = shadow_cnts[pos];
				end else
					t.status = ST_ABSENT;
			end
		endcase
		t.total_count = shadow_total;
		t.distinct_count = DIST_BITS'(shadow_used);
		return t;
	endfunction

	always @(posedge clk) begin : watch_streams
		tally_t want;
		tally_t predicted;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_tallies.size() == 0)
					report_mismatch("result beat with nothing expected", 0, 1);
				else begin
					want = pending_tallies.pop_front();
					if (m_axis_tuser != want.status)
						report_mismatch("status", want.status, m_axis_tuser);
					if (m_axis_tdata[0] != want.present)
						report_mismatch("present", want.present, m_axis_tdata[0]);
					if (m_axis_tdata[16:1] != want.occurrences)
						report_mismatch("occurrences", want.occurrences, m_axis_tdata[16:1]);
					if (m_axis_tdata[38:17] != want.total_count)
						report_mismatch("total_count", want.total_count, m_axis_tdata[38:17]);
					if (m_axis_tdata[45:39] != want.distinct_count)
						report_mismatch("distinct_count", want.distinct_count,
						                m_axis_tdata[45:39]);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				predicted = apply_request(s_axis_tuser, s_axis_tdata);
				pending_tallies.push_back(beat_literal ? beat_want : predicted);
			end
			if (cfg_valid && cfg_ready)
				order_desc = cfg_data;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[sorted_multiset_table_core] ERROR");
				$finish;
			end
		end
	end

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic offer_request(input logic [REQ_BITS-1:0] req, input logic [ITEM_BITS-1:0] value,
	                             input bit literal, input tally_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		s_axis_tuser <= req;
		beat_literal = literal;
		beat_want = want;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic offer_random(input int beats);
		logic [REQ_BITS-1:0]  req;
		logic [ITEM_BITS-1:0] value;
		int                   roll;
		repeat (beats) begin
			roll = $urandom_range(99);
			if (roll < 45)
				req = REQ_ADD;
			else if (roll < 75)
				req = REQ_REMOVE;
			else if (roll < 90)
				req = REQ_QUERY;
			else
				req = REQ_SPARE;
			roll = $urandom_range(99);
			if (shadow_used != 0 && roll < 55)
				value = shadow_vals[$urandom_range(shadow_used - 1)];
			else if (roll < 85)
				value = value_pool[$urandom_range(POOL_SIZE - 1)];
			else
				value = $urandom;
			offer_request(req, value, 1'b0, '0);
		end
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_tallies.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_order(input bit desc);
		cfg_valid <= 1'b1;
		cfg_data <= desc;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [ITEM_BITS-1:0] fresh;
		bit                   hit;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		beat_literal = 1'b0;
		beat_want = '0;
		hold_request = 1'b0;
		mismatch_count = 0;
		quiet_cycles = 0;
		order_desc = 1'b0;
		shadow_used = 0;
		shadow_total = '0;
		send_idle_pct = 7;
		recv_idle_pct = 52;
		foreach (value_pool[k])
			value_pool[k] = $urandom;
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7FFF_FFFF;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hFFFF_FFFF;

		probe_rows = '{
			'{REQ_QUERY,  32'h0000_0000, 1'b1, '{ST_ABSENT, 1'b0, 16'd0, 22'd0, 7'd0}},
			'{REQ_REMOVE, 32'h0000_0005, 1'b1, '{ST_ABSENT, 1'b0, 16'd0, 22'd0, 7'd0}},
			'{REQ_SPARE,  32'h0000_0007, 1'b1, '{ST_ABSENT, 1'b0, 16'd0, 22'd0, 7'd0}},
			'{REQ_ADD,    32'h8000_0000, 1'b1, '{ST_OK, 1'b1, 16'd1, 22'd1, 7'd1}},
			'{REQ_ADD,    32'h7FFF_FFFF, 1'b1, '{ST_OK, 1'b1, 16'd1, 22'd2, 7'd2}},
			'{REQ_ADD,    32'h0000_0000, 1'b1, '{ST_OK, 1'b1, 16'd1, 22'd3, 7'd3}},
			'{REQ_ADD,    32'h7FFF_FFFF, 1'b1, '{ST_OK, 1'b1, 16'd2, 22'd4, 7'd3}},
			'{REQ_ADD,    32'hFFFF_FFFF, 1'b0, '0},
			'{REQ_ADD,    32'h0000_0001, 1'b0, '0},
			'{REQ_QUERY,  32'h7FFF_FFFF, 1'b0, '0},
			'{REQ_SPARE,  32'h0000_0000, 1'b0, '0},
			'{REQ_REMOVE, 32'h7FFF_FFFF, 1'b0, '0},
			'{REQ_REMOVE, 32'h7FFF_FFFF, 1'b0, '0},
			'{REQ_REMOVE, 32'h7FFF_FFFF, 1'b0, '0},
			'{REQ_REMOVE, 32'h8000_0000, 1'b0, '0},
			'{REQ_QUERY,  32'h8000_0000, 1'b0, '0},
			'{REQ_ADD,    32'h5555_5555, 1'b0, '0},
			'{REQ_ADD,    32'hAAAA_AAAA, 1'b0, '0},
			'{REQ_REMOVE, 32'h0000_0002, 1'b0, '0},
			'{REQ_QUERY,  32'hFFFF_FFFF, 1'b0, '0},
			'{REQ_ADD,    32'h8000_0000, 1'b0, '0},
			'{REQ_REMOVE, 32'h0000_0000, 1'b0, '0}
		};

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		write_order(1'b0);

		foreach (probe_rows[r])
			offer_request(probe_rows[r].req, probe_rows[r].value, probe_rows[r].literal,
			              probe_rows[r].want);
		offer_random(130);
		settle();

		// descending, sender idles more, receiver stalls long once
		write_order(1'b1);
		send_idle_pct = 52;
		recv_idle_pct = 7;
		hold_request = 1'b1;
		offer_random(130);
		settle();

		// ascending, no idling: fill the table and hit the capacity
		write_order(1'b0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (shadow_used < MAX_DISTINCT)
			offer_request(REQ_ADD, $urandom, 1'b0, '0);
		do begin
			fresh = $urandom;
			void'(locate(fresh, hit));
		end while (hit);
		offer_request(REQ_ADD, fresh, 1'b0, '0);
		offer_request(REQ_ADD, shadow_vals[$urandom_range(MAX_DISTINCT - 1)], 1'b0, '0);
		offer_request(REQ_REMOVE, shadow_vals[0], 1'b0, '0);
		offer_request(REQ_REMOVE, shadow_vals[MAX_DISTINCT - 1], 1'b0, '0);
		offer_random(80);

		fresh = (shadow_used != 0) ? shadow_vals[0] : $urandom;
		offer_request(REQ_ADD, fresh, 1'b0, '0);
		offer_request(REQ_REMOVE, fresh, 1'b0, '0);
		offer_request(REQ_QUERY, fresh, 1'b0, '0);
		settle();

		// order flipped on a loaded table
		write_order(1'b1);
		offer_random(40);
		settle();

		if (mismatch_count == 0)
			$display("[sorted_multiset_table_core] OK");
		else
			$display("[sorted_multiset_table_core] ERROR");
		$finish;
	end

endmodule
